// ===== sv/detection_row_decode_defines.svh =====
// assertion macros shared by the detection row decoder rtl
// no dependencies; included by modules that carry concurrent checks
`ifndef DETECTION_ROW_DECODE_DEFINES_SVH
`define DETECTION_ROW_DECODE_DEFINES_SVH

// property must hold at every clock edge outside reset
`define DRD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// condition must never be seen outside reset
`define DRD_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  `DRD_ASSERT(lbl, clk, rstn, !(cond), msg)

`endif

// ===== sv/drd_pkg.sv =====
// shared types and constants of the detection row decoder
// no dependencies; imported by every drd module and the top level
package drd_pkg;

  localparam int unsigned BoxCount   = 4;
  localparam int unsigned MaxClasses = 128;
  localparam int unsigned PosW       = 9;
  localparam int unsigned QueueDepth = 2;

  localparam logic [16:0] ScoreOne   = 17'd65536;
  localparam logic [15:0] PixMax     = 16'hffff;

  // configuration register map, index = byte address / 4
  typedef enum logic [2:0] {
    RegHasObj   = 3'd0,
    RegNumCls   = 3'd1,
    RegThresh   = 3'd2,
    RegInvX     = 3'd3,
    RegInvY     = 3'd4,
    RegPadX     = 3'd5,
    RegPadY     = 3'd6
  } reg_idx_e;

  localparam logic        RstHasObj = 1'b1;
  localparam logic [7:0]  RstNumCls = 8'd80;
  localparam logic [16:0] RstThresh = 17'd16384;
  localparam logic [31:0] RstInv    = 32'd65536;
  localparam logic [31:0] RstPad    = 32'd0;

  typedef struct packed {
    logic        has_obj;
    logic [7:0]  num_classes;
    logic [16:0] threshold;
    logic [31:0] inv_x;
    logic [31:0] inv_y;
    logic [31:0] pad_x;
    logic [31:0] pad_y;
  } cfg_t;

  // one finished row handed from front to back
  typedef struct packed {
    logic [BoxCount-1:0][31:0] box;
    logic [31:0]               obj;
    logic [31:0]               best;
    logic [6:0]                idx;
  } row_rec_t;

  typedef struct packed {
    logic [15:0] box_height;
    logic [15:0] box_width;
    logic [15:0] box_top;
    logic [15:0] box_left;
    logic [16:0] score;
    logic [6:0]  class_id;
  } result_t;

endpackage

// ===== sv/detection_row_decode.sv =====
// detection row decoder top level: config registers, front, queue, back
// depends on drd_pkg, drd_front, drd_fifo and drd_back
//
// input stream: one signed q16.16 row element per transfer on s_axis_tdata_i,
// s_axis_tlast_i marks the last element of a row (cx, cy, w, h, optional
// objectness, class scores). one element is taken every cycle while the row
// queue has room, so rows stream at a sustained one element per cycle.
// output stream: at most one detection per row, issued after the row's last
// transfer when the tested score beats the threshold. the result reaches
// m_axis_tvalid_o after that last transfer has passed the queue, the three
// arithmetic stages and the result register. the back part takes one row
// per cycle while no result is held, and then never limits rows of five or more elements.
// stall: a held result freezes the back stages; the two-entry row queue then
// fills and s_axis_tready_o drops until the receiver takes the result.
// reset: registers return to their defaults, row position and queue clear, no result is
// pending. the user writes configuration over apb only while idle; not enforced.
module detection_row_decode (
  input  logic        clk_i,
  input  logic        rst_ni,
  // apb configuration port, register i at byte address 4*i
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // row element stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // [31:0] value
  input  logic        s_axis_tlast_i,  // row_end
  // detection stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [87:0] m_axis_tdata_o   // [6:0] class_id, [23:7] score, [39:24] box_left,
                                       // [55:40] box_top, [71:56] box_width,
                                       // [87:72] box_height
);
  import drd_pkg::*;

  cfg_t     cfg_q;
  logic     cfg_wr;
  reg_idx_e cfg_idx;

  logic     push;
  row_rec_t push_data;
  logic     pop;
  row_rec_t pop_data;
  logic     q_full;
  logic     q_empty;
  result_t  res;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[4:2]);

  // register write, taken in the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.has_obj     <= RstHasObj;
      cfg_q.num_classes <= RstNumCls;
      cfg_q.threshold   <= RstThresh;
      cfg_q.inv_x       <= RstInv;
      cfg_q.inv_y       <= RstInv;
      cfg_q.pad_x       <= RstPad;
      cfg_q.pad_y       <= RstPad;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        RegHasObj: cfg_q.has_obj     <= pwdata[0];
        RegNumCls: cfg_q.num_classes <= pwdata[7:0];
        RegThresh: cfg_q.threshold   <= pwdata[16:0];
        RegInvX:   cfg_q.inv_x       <= pwdata;
        RegInvY:   cfg_q.inv_y       <= pwdata;
        RegPadX:   cfg_q.pad_x       <= pwdata;
        RegPadY:   cfg_q.pad_y       <= pwdata;
        default:   ;  // unmapped address, write ignored
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (cfg_idx)
      RegHasObj: prdata = {31'b0, cfg_q.has_obj};
      RegNumCls: prdata = {24'b0, cfg_q.num_classes};
      RegThresh: prdata = {15'b0, cfg_q.threshold};
      RegInvX:   prdata = cfg_q.inv_x;
      RegInvY:   prdata = cfg_q.inv_y;
      RegPadX:   prdata = cfg_q.pad_x;
      RegPadY:   prdata = cfg_q.pad_y;
      default:   prdata = '0;
    endcase
  end

  // front: classifies each element and builds the row record
  drd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_value_i  (s_axis_tdata_i),
    .in_last_i   (s_axis_tlast_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // finished rows wait here so front and back stall independently
  drd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  // back: threshold, box mapping, output register
  drd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_empty_i   (q_empty),
    .q_data_i    (pop_data),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (res)
  );

  // class_id in the lowest bits, box_height in the highest
  assign m_axis_tdata_o = {res.box_height, res.box_width, res.box_top,
                           res.box_left, res.score, res.class_id};

endmodule

// ===== sv/drd_fifo.sv =====
// short row queue between the front and back parts of the decoder
// depends on drd_pkg and detection_row_decode_defines.svh
`include "detection_row_decode_defines.svh"

module drd_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  drd_pkg::row_rec_t push_data_i,
  input  logic              pop_i,
  output drd_pkg::row_rec_t pop_data_o,
  output logic              full_o,
  output logic              empty_o
);
  import drd_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QueueDepth);

  row_rec_t        mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o     = (count_q == FullCnt);
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `DRD_ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, push_i && full_o, "row pushed into full queue")
  `DRD_ASSERT_NEVER(a_no_underflow, clk_i, rst_ni, pop_i && empty_o, "row popped from empty queue")
  `DRD_ASSERT(a_count_up, clk_i, rst_ni, (push_i && !pop_i) |=> (count_q == $past(count_q) + 1'b1), "queue count did not grow")
  `DRD_ASSERT(a_count_dn, clk_i, rst_ni, (pop_i && !push_i) |=> (count_q == $past(count_q) - 1'b1), "queue count did not shrink")

endmodule

// ===== sv/drd_front.sv =====
// front part: walks the row, keeps box values, objectness and running argmax
// depends on drd_pkg; hands a row record to the queue at row end
module drd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  drd_pkg::cfg_t     cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [31:0]       in_value_i,
  input  logic              in_last_i,
  input  logic              q_full_i,
  output logic              push_o,
  output drd_pkg::row_rec_t push_data_o
);
  import drd_pkg::*;

  localparam logic [PosW-1:0] PosMax = '1;
  localparam logic [PosW-1:0] BoxN   = PosW'(BoxCount);
  localparam logic [PosW-1:0] ClsMax = PosW'(MaxClasses);

  logic [PosW-1:0]           pos_q, pos_d;
  logic [BoxCount-1:0][31:0] box_q, box_d;
  logic [31:0]               obj_q, obj_d;
  logic [31:0]               best_q, best_d;
  logic [6:0]                idx_q, idx_d;

  logic            accept;
  logic [PosW-1:0] header;
  logic [PosW-1:0] ncls;
  logic [PosW-1:0] cls_pos;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign header     = BoxN + PosW'(cfg_i.has_obj);
  assign cls_pos    = pos_q - header;

  always_comb begin
    ncls = (cfg_i.num_classes == '0) ? PosW'(1) : PosW'(cfg_i.num_classes);
    if (ncls > ClsMax) begin
      ncls = ClsMax;
    end
  end

  always_comb begin
    pos_d  = pos_q;
    box_d  = box_q;
    obj_d  = obj_q;
    best_d = best_q;
    idx_d  = idx_q;
    push_o = 1'b0;
    if (accept) begin
      if (pos_q < BoxN) begin
        box_d[pos_q[1:0]] = in_value_i;
      end else if (pos_q < header) begin
        obj_d = in_value_i;
      end else if ((cls_pos == '0) ||
                   ((cls_pos < ncls) && ($signed(in_value_i) > $signed(best_q)))) begin
        best_d = in_value_i;
        idx_d  = cls_pos[6:0];
      end
      if (!in_last_i) begin
        if (pos_q != PosMax) begin
          pos_d = pos_q + 1'b1;
        end
      end else begin
        pos_d  = '0;
        // a row that ends before any class score yields nothing
        push_o = (pos_q >= header);
      end
    end
  end

  assign push_data_o = '{box: box_d, obj: obj_d, best: best_d, idx: idx_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      idx_q <= '0;
    end else begin
      pos_q <= pos_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    box_q  <= box_d;
    obj_q  <= obj_d;
    best_q <= best_d;
  end

endmodule

// ===== sv/drd_back.sv =====
// back part: threshold test, letterbox mapping and rounding in four stages
// depends on drd_pkg; pops rows from the queue, drives the result register
module drd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  drd_pkg::cfg_t     cfg_i,
  input  logic              q_empty_i,
  input  drd_pkg::row_rec_t q_data_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output drd_pkg::result_t  out_data_o
);
  import drd_pkg::*;

  localparam logic [63:0] MagLimit = 64'h2000_0000_0000_0000;
  localparam logic [62:0] Half     = 63'h0000_0000_8000_0000;

  logic en;

  // stage 1: signs, magnitudes, threshold test
  logic                      s1_vld_q, s1_pass_q;
  logic [BoxCount-1:0]       s1_sgn_q;
  logic [BoxCount-1:0][31:0] s1_mag_q;
  logic [31:0]               s1_best_q, s1_obj_q;
  logic [6:0]                s1_idx_q;
  // stage 2: products
  logic                      s2_vld_q, s2_pass_q;
  logic [BoxCount-1:0]       s2_sgn_q;
  logic [BoxCount-1:0][63:0] s2_prod_q;
  logic signed [63:0]        s2_conf_q;
  logic [31:0]               s2_best_q;
  logic [6:0]                s2_idx_q;
  // stage 3: saturated signed q32.32 values, clamped score
  logic                      s3_vld_q, s3_pass_q;
  logic [BoxCount-1:0][62:0] s3_val_q;
  logic [16:0]               s3_score_q;
  logic [6:0]                s3_idx_q;
  // result register
  logic                      out_vld_q;
  result_t                   res_q;

  logic [BoxCount-1:0]       s1_sgn_d;
  logic [BoxCount-1:0][31:0] s1_mag_d;
  logic                      s1_pass_d;
  logic [BoxCount-1:0][62:0] s3_val_d;
  logic [16:0]               s3_score_d;
  result_t                   res_d;

  assign en          = !out_vld_q || out_ready_i;
  assign pop_o       = en && !q_empty_i;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = res_q;

  always_comb begin
    logic [31:0] pad;
    logic [32:0] dif;
    logic [32:0] neg;
    logic [31:0] tested;
    for (int i = 0; i < BoxCount; i++) begin
      pad         = (i < 2) ? ((i == 0) ? cfg_i.pad_x : cfg_i.pad_y) : '0;
      dif         = {q_data_i.box[i][31], q_data_i.box[i]} - {pad[31], pad};
      neg         = 33'(-dif);
      s1_sgn_d[i] = dif[32];
      s1_mag_d[i] = dif[32] ? neg[31:0] : dif[31:0];
    end
    tested    = cfg_i.has_obj ? q_data_i.obj : q_data_i.best;
    s1_pass_d = $signed(tested) > $signed({15'b0, cfg_i.threshold});
  end

  always_comb begin
    logic [61:0] psat;
    logic [62:0] ext;
    logic [47:0] c48;
    for (int i = 0; i < BoxCount; i++) begin
      psat        = (s2_prod_q[i] > MagLimit) ? MagLimit[61:0] : s2_prod_q[i][61:0];
      ext         = {1'b0, psat};
      s3_val_d[i] = s2_sgn_q[i] ? 63'(-ext) : ext;
    end
    c48 = s2_conf_q[63:16];
    if (cfg_i.has_obj) begin
      if (s2_conf_q <= 64'sd0) begin
        s3_score_d = '0;
      end else begin
        s3_score_d = (c48 > 48'(ScoreOne)) ? ScoreOne : c48[16:0];
      end
    end else begin
      if (s2_best_q[31]) begin
        s3_score_d = '0;
      end else begin
        s3_score_d = (s2_best_q > 32'(ScoreOne)) ? ScoreOne : s2_best_q[16:0];
      end
    end
  end

  always_comb begin
    logic [64:0] twice;
    logic [31:0] er;
    logic [62:0] rnd;
    logic [30:0] sr;
    logic [15:0] edge_px [2];
    logic [15:0] size_px [2];
    for (int i = 0; i < 2; i++) begin
      // left/top: floor((2*center - size) / 2^33), clamped at zero
      twice = {s3_val_q[i][62], s3_val_q[i], 1'b0} -
              {{2{s3_val_q[i+2][62]}}, s3_val_q[i+2]};
      er    = twice[64:33];
      if (twice[64] || (twice == '0)) begin
        edge_px[i] = '0;
      end else begin
        edge_px[i] = (|er[31:16]) ? PixMax : er[15:0];
      end
      // width/height: round half up to whole pixels
      rnd = {1'b0, s3_val_q[i+2][61:0]} + Half;
      sr  = rnd[62:32];
      if (s3_val_q[i+2][62]) begin
        size_px[i] = '0;
      end else begin
        size_px[i] = (|sr[30:16]) ? PixMax : sr[15:0];
      end
    end
    res_d = '{box_height: size_px[1], box_width: size_px[0],
              box_top: edge_px[1], box_left: edge_px[0],
              score: s3_score_q, class_id: s3_idx_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q  <= !q_empty_i;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      out_vld_q <= s3_vld_q && s3_pass_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_pass_q  <= s1_pass_d;
      s1_sgn_q   <= s1_sgn_d;
      s1_mag_q   <= s1_mag_d;
      s1_best_q  <= q_data_i.best;
      s1_obj_q   <= q_data_i.obj;
      s1_idx_q   <= q_data_i.idx;
      s2_pass_q  <= s1_pass_q;
      s2_sgn_q   <= s1_sgn_q;
      for (int i = 0; i < BoxCount; i++) begin
        s2_prod_q[i] <= 64'(s1_mag_q[i]) * 64'(i[0] ? cfg_i.inv_y : cfg_i.inv_x);
      end
      s2_conf_q  <= 64'($signed(s1_best_q)) * 64'($signed(s1_obj_q));
      s2_best_q  <= s1_best_q;
      s2_idx_q   <= s1_idx_q;
      s3_pass_q  <= s2_pass_q;
      s3_val_q   <= s3_val_d;
      s3_score_q <= s3_score_d;
      s3_idx_q   <= s2_idx_q;
      res_q      <= res_d;
    end
  end

endmodule

// ===== sim/drd_detection_checker.sv =====
`timescale 1ns / 1ps
// detection checker: follows apb writes, predicts the detection of every row
// and compares it with the output stream; depends on drd_pkg only
module drd_detection_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [31:0] s_axis_tdata_i,  // [31:0] value
  input  logic        s_axis_tlast_i,  // row_end
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [87:0] m_axis_tdata_i,  // [6:0] class_id, [23:7] score, [39:24] box_left,
                                       // [55:40] box_top, [71:56] box_width,
                                       // [87:72] box_height
  output int unsigned errors_o,
  output int unsigned pending_o
);
  import drd_pkg::*;

  localparam logic [63:0] MagLimit = 64'h2000_0000_0000_0000;
  localparam int unsigned PosLimit = 511;

  cfg_t        cfg;
  int unsigned row_pos;
  logic [31:0] box_val [BoxCount];
  logic [31:0] obj_val;
  logic [31:0] best_val;
  logic [6:0]  best_cls;
  result_t     pending_dets [$];
  int unsigned mismatches;

  function automatic longint sx(logic [31:0] v);
    return longint'($signed(v));
  endfunction

  // signed q32.32 product, magnitude clipped
  function automatic longint scaled(longint d, logic [31:0] inv);
    logic [63:0] mag;
    logic [63:0] p;
    mag = (d < 0) ? 64'(-d) : 64'(d);
    p = mag * {32'd0, inv};
    if (p > MagLimit) p = MagLimit;
    return (d < 0) ? -longint'(p) : longint'(p);
  endfunction

  function automatic logic [15:0] edge_pixel(longint ctr, longint sz);
    longint      twice;
    logic [63:0] r;
    twice = 2 * ctr - sz;
    if (twice <= 0) return 16'd0;
    r = 64'(twice) >> 33;
    return (r > 64'd65535) ? PixMax : r[15:0];
  endfunction

  function automatic logic [15:0] size_pixel(longint sz);
    logic [63:0] r;
    if (sz < 0) return 16'd0;
    r = (64'(sz) + 64'h8000_0000) >> 32;
    return (r > 64'd65535) ? PixMax : r[15:0];
  endfunction

  // one row element; returns 1 when it closes a row that yields a detection
  function automatic bit decode_element(logic [31:0] v, logic last, output result_t det);
    int unsigned hdr;
    int unsigned ncls;
    int unsigned c;
    longint      tested;
    longint      conf;
    longint      cx;
    longint      cy;
    longint      w;
    longint      h;
    det = '0;
    hdr = BoxCount + cfg.has_obj;
    ncls = (cfg.num_classes == 0) ? 1 : cfg.num_classes;
    if (ncls > MaxClasses) ncls = MaxClasses;

    if (row_pos < BoxCount) begin
      box_val[row_pos] = v;
    end else if (row_pos < hdr) begin
      obj_val = v;
    end else begin
      c = row_pos - hdr;
      if (c == 0 || (c < ncls && sx(v) > sx(best_val))) begin
        best_val = v;
        best_cls = 7'(c);
      end
    end

    if (!last) begin
      if (row_pos < PosLimit) row_pos++;
      return 1'b0;
    end
    if (row_pos < hdr) begin
      row_pos = 0;
      return 1'b0;
    end
    row_pos = 0;

    if (cfg.has_obj) begin
      tested = sx(obj_val);
      conf = sx(best_val) * tested;
      conf = (conf <= 0) ? 0 : (conf >>> 16);
    end else begin
      tested = sx(best_val);
      conf = (tested < 0) ? 0 : tested;
    end
    if (tested <= longint'(cfg.threshold)) return 1'b0;
    if (conf > 65536) conf = 65536;

    cx = scaled(sx(box_val[0]) - sx(cfg.pad_x), cfg.inv_x);
    cy = scaled(sx(box_val[1]) - sx(cfg.pad_y), cfg.inv_y);
    w  = scaled(sx(box_val[2]), cfg.inv_x);
    h  = scaled(sx(box_val[3]), cfg.inv_y);

    det.class_id   = best_cls;
    det.score      = 17'(conf);
    det.box_left   = edge_pixel(cx, w);
    det.box_top    = edge_pixel(cy, h);
    det.box_width  = size_pixel(w);
    det.box_height = size_pixel(h);
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    bit      hit;
    if (!rst_ni) begin
      cfg = '{has_obj: RstHasObj, num_classes: RstNumCls, threshold: RstThresh,
              inv_x: RstInv, inv_y: RstInv, pad_x: RstPad, pad_y: RstPad};
      row_pos = 0;
      best_cls = '0;
      pending_dets.delete();
      mismatches = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[4:2]))
          RegHasObj: cfg.has_obj     = pwdata[0];
          RegNumCls: cfg.num_classes = pwdata[7:0];
          RegThresh: cfg.threshold   = pwdata[16:0];
          RegInvX:   cfg.inv_x       = pwdata;
          RegInvY:   cfg.inv_y       = pwdata;
          RegPadX:   cfg.pad_x       = pwdata;
          RegPadY:   cfg.pad_y       = pwdata;
          default: ;
        endcase
      end

      if (s_axis_tvalid_i && s_axis_tready_i) begin
        hit = decode_element(s_axis_tdata_i, s_axis_tlast_i, want);
        if (hit) pending_dets.insert(pending_dets.size(), want);
      end

      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = result_t'(m_axis_tdata_i);
        if (pending_dets.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected detection class %0d score %0d box %0d,%0d %0dx%0d",
                     $time, got.class_id, got.score, got.box_left, got.box_top,
                     got.box_width, got.box_height);
          mismatches++;
        end else begin
          want = pending_dets.pop_front();
          if (got.class_id !== want.class_id || got.score !== want.score ||
              got.box_left !== want.box_left || got.box_top !== want.box_top ||
              got.box_width !== want.box_width || got.box_height !== want.box_height) begin
            if (mismatches < 10) begin
              $display("%0t: detection mismatch", $time);
              $display("  expected class %0d score %0d box %0d,%0d %0dx%0d",
                       want.class_id, want.score, want.box_left, want.box_top,
                       want.box_width, want.box_height);
              $display("  actual   class %0d score %0d box %0d,%0d %0dx%0d",
                       got.class_id, got.score, got.box_left, got.box_top,
                       got.box_width, got.box_height);
            end
            mismatches++;
          end
        end
      end
    end
    errors_o  <= mismatches;
    pending_o <= pending_dets.size();
  end

endmodule

// ===== sim/tb_detection_row_decode.sv =====
`timescale 1ns / 1ps
// testbench top of the detection row decoder: clock, reset, apb setup, row
// stimulus and verdict; depends on drd_pkg, drd_detection_checker and the rtl
module tb_detection_row_decode;
  import drd_pkg::*;

  localparam int unsigned ItemTarget  = 1350;
  localparam int unsigned QuietItems  = 1150;   // from here on no idling at all
  localparam int unsigned DrainCycles = 12;     // lets rows without a result drain through the back stages
  localparam int unsigned LongRowLen  = 530;    // beyond the 511 position ceiling
  localparam longint      LimitNs     = 5_000_000;

  typedef enum int unsigned {RowFull, RowExtra, RowShort, RowNoise, RowLong} row_kind_e;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i;  // [31:0] value
  logic        s_axis_tlast_i;  // row_end
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [87:0] m_axis_tdata_o;  // [6:0] class_id, [23:7] score, [39:24] box_left,
                                // [55:40] box_top, [71:56] box_width,
                                // [87:72] box_height

  int unsigned mismatches;
  int unsigned pending;

  // idling controls for the sender and the receiver
  int unsigned gap_pct;
  int unsigned stall_pct;
  bit          quiet;

  // configuration as last programmed, used to shape well-formed rows
  cfg_t        active_cfg;
  int unsigned items_sent;

  detection_row_decode DUT (.*);

  drd_detection_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .pready          (pready),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_i (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_i (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_i  (m_axis_tdata_o),
    .errors_o        (mismatches),
    .pending_o       (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hard stop in case a transfer or a detection never completes
  initial begin
    #(LimitNs);
    $display("Simulation FAILED");
    $finish;
  end

  // receiver: per-cycle chance of a stall burst
  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!quiet && $urandom_range(0, 99) < stall_pct) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
    end
  end

  // apb write: setup cycle, then access cycle held until pready
  task automatic apb_write(reg_idx_e idx, logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic program_config(cfg_t c);
    active_cfg = c;
    apb_write(RegHasObj, {31'd0, c.has_obj});
    apb_write(RegNumCls, {24'd0, c.num_classes});
    apb_write(RegThresh, {15'd0, c.threshold});
    apb_write(RegInvX, c.inv_x);
    apb_write(RegInvY, c.inv_y);
    apb_write(RegPadX, c.pad_x);
    apb_write(RegPadY, c.pad_y);
  endtask

  // one element transfer, optionally preceded by an idle burst; tvalid stays
  // high after the transfer so back-to-back elements need no extra edge
  task automatic send_item(logic [31:0] v, logic last);
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= v;
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    items_sent++;
  endtask

  // everything expected has come out, then let rows without a result drain
  task automatic wait_idle();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic int unsigned eff_classes(cfg_t c);
    if (c.num_classes == 0) return 1;
    if (c.num_classes > MaxClasses) return MaxClasses;
    return c.num_classes;
  endfunction

  function automatic logic [31:0] extreme_word();
    case ($urandom_range(0, 3))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  // centers in 0..700 px, sizes in 0..400 px, with some wild values mixed in
  function automatic logic [31:0] box_word(int unsigned i);
    case ($urandom_range(0, 9))
      0:       return $urandom();
      1:       return extreme_word();
      2:       return -{16'($urandom_range(0, 50)), 16'($urandom())};
      default: return {16'($urandom_range(0, (i < 2) ? 700 : 400)), 16'($urandom())};
    endcase
  endfunction

  // scores mostly around 0..1.07, so thresholds split rows into kept and dropped
  function automatic logic [31:0] score_word();
    case ($urandom_range(0, 9))
      0:       return $urandom();
      1:       return extreme_word();
      2:       return -{16'd0, 16'($urandom())};
      default: return 32'($urandom_range(0, 70000));
    endcase
  endfunction

  function automatic logic [31:0] inv_word();
    case ($urandom_range(0, 7))
      0:       return 32'd0;
      1:       return 32'hffff_ffff;
      2:       return 32'd65536;
      3:       return $urandom();
      default: return 32'($urandom_range(16384, 262144));
    endcase
  endfunction

  function automatic logic [31:0] pad_word();
    case ($urandom_range(0, 7))
      0:       return 32'd0;
      1:       return 32'h8000_0000;
      2:       return 32'h7fff_ffff;
      3:       return $urandom();
      4:       return -{16'($urandom_range(0, 100)), 16'($urandom())};
      default: return {16'($urandom_range(0, 100)), 16'($urandom())};
    endcase
  endfunction

  function automatic cfg_t random_cfg();
    cfg_t c;
    c.has_obj = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 15))
      0:       c.num_classes = 8'd0;    // acts as one class
      1:       c.num_classes = 8'd128;
      2:       c.num_classes = 8'd255;  // above the class ceiling
      3:       c.num_classes = 8'($urandom_range(9, 127));
      default: c.num_classes = 8'($urandom_range(1, 8));
    endcase
    case ($urandom_range(0, 5))
      0:       c.threshold = 17'd0;
      1:       c.threshold = ScoreOne;
      default: c.threshold = 17'($urandom_range(0, 65536));
    endcase
    c.inv_x = inv_word();
    c.inv_y = inv_word();
    c.pad_x = pad_word();
    c.pad_y = pad_word();
    return c;
  endfunction

  function automatic int unsigned pick_rate();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 10;
      2:       return 30;
      default: return 60;
    endcase
  endfunction

  // one row shaped after the programmed layout; ties between class scores are
  // made on purpose so the first-maximum rule gets exercised
  task automatic send_row(row_kind_e kind);
    int unsigned hdr;
    int unsigned ncls;
    int unsigned len;
    int unsigned i;
    logic [31:0] prev;
    logic [31:0] v;
    hdr  = BoxCount + active_cfg.has_obj;
    ncls = eff_classes(active_cfg);
    case (kind)
      RowShort: len = $urandom_range(1, hdr);            // ends before any class score
      RowExtra: len = hdr + ncls + $urandom_range(1, 6); // trailing values ignored
      RowNoise: len = $urandom_range(1, hdr + ncls + 4);
      RowLong:  len = LongRowLen;
      default:  len = hdr + ncls;
    endcase
    prev = '0;
    for (i = 0; i < len; i++) begin
      if (kind == RowNoise)
        v = $urandom();
      else if (i < BoxCount)
        v = box_word(i);
      else if (i > hdr && $urandom_range(0, 4) == 0)
        v = prev;
      else
        v = score_word();
      prev = v;
      send_item(v, i == len - 1);
    end
  endtask

  initial begin
    int unsigned rows;
    int unsigned pick;
    row_kind_e   kind;
    bit          first_phase;

    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tlast_i  = 1'b0;
    gap_pct         = 20;
    stall_pct       = 20;
    quiet           = 1'b0;
    items_sent      = 0;
    first_phase     = 1'b1;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: three classes, zero threshold, unit x scale, extreme y scale and pads
    program_config('{has_obj: 1'b1, num_classes: 8'd3, threshold: 17'd0,
                     inv_x: 32'd65536, inv_y: 32'hffff_ffff,
                     pad_x: 32'h7fff_ffff, pad_y: 32'h8000_0000});

    // extreme box values, tie on the first two classes, score clipped to one
    send_item(32'h7fff_ffff, 1'b0);
    send_item(32'h8000_0000, 1'b0);
    send_item(32'h7fff_ffff, 1'b0);
    send_item(32'h8000_0000, 1'b0);
    send_item(32'h7fff_ffff, 1'b0);
    send_item(32'h0001_0000, 1'b0);
    send_item(32'h0001_0000, 1'b0);
    send_item(32'h8000_0000, 1'b1);
    // short row inside the box values
    send_item(32'h0000_0000, 1'b0);
    send_item(32'hffff_ffff, 1'b1);
    // row that stops on the objectness, no class seen
    send_item(32'h0064_0000, 1'b0);
    send_item(32'h0032_0000, 1'b0);
    send_item(32'h0014_0000, 1'b0);
    send_item(32'h000a_0000, 1'b0);
    send_item(32'h0000_c000, 1'b1);
    // class count changed in the middle of a row, then a trailing value
    send_item(32'h0064_0000, 1'b0);
    send_item(32'h0032_0000, 1'b0);
    send_item(32'h0014_0000, 1'b0);
    send_item(32'h000a_0000, 1'b0);
    send_item(32'h0000_c000, 1'b0);
    send_item(32'h8000_0000, 1'b0);
    s_axis_tvalid_i <= 1'b0;
    wait_idle();
    apb_write(RegNumCls, 32'd2);
    active_cfg.num_classes = 8'd2;
    send_item(32'h7fff_ffff, 1'b0);
    send_item(32'h7fff_ffff, 1'b0);
    send_item(32'h1234_5678, 1'b1);
    s_axis_tvalid_i <= 1'b0;
    wait_idle();

    // random phases: new settings each phase, written only while idle
    while (items_sent < ItemTarget) begin
      quiet     = (items_sent >= QuietItems);
      gap_pct   = quiet ? 0 : pick_rate();
      stall_pct = quiet ? 0 : pick_rate();
      program_config(random_cfg());
      if (first_phase) begin
        send_row(RowLong);
        first_phase = 1'b0;
      end
      rows = (eff_classes(active_cfg) > 16) ? 2 : $urandom_range(4, 12);
      repeat (rows) begin
        pick = $urandom_range(0, 19);
        if (pick < 2)       kind = RowShort;
        else if (pick < 4)  kind = RowExtra;
        else if (pick == 4) kind = RowNoise;
        else                kind = RowFull;
        send_row(kind);
      end
      s_axis_tvalid_i <= 1'b0;
      wait_idle();
    end

    if (mismatches == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
